FILE: sv/dll_pkg.sv
// ============================================================================
// dll_pkg: shared types and constants for the linked byte list unit
// Field widths, operation and status codes, sequencer states, and the
// structs that carry node memory accesses between control and storage.
// ============================================================================
package dll_pkg;

   // Fixed field widths
   localparam int BYTE_W   = 8;
   localparam int LINK_W   = 6;
   localparam int FUNC_W   = 3;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 6;

   // Default node pool size
   localparam int POOL_DEPTH_DEF = 32;

   // Operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_TAIL = 3'd0,
      FN_PUSH_HEAD = 3'd1,
      FN_INSERT    = 3'd2,
      FN_DELETE    = 3'd3,
      FN_READ_FWD  = 3'd4,
      FN_READ_BWD  = 3'd5,
      FN_CLEAR     = 3'd6
   } func_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PUSH_WR,
      ST_FIND,
      ST_INS_WR,
      ST_INS_LINK,
      ST_DEL_WR,
      ST_DEL_GIVE,
      ST_WALK,
      ST_RESP
   } state_type;

   // Input item
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] key;
   } req_type;

   // Result item
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [BYTE_W-1:0]  data;
      logic               last;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   // Write side of the node memory: one port per field array
   typedef struct packed {
      logic              byte_we;
      logic [LINK_W-1:0] byte_addr;
      logic [BYTE_W-1:0] byte_data;
      logic              next_we;
      logic [LINK_W-1:0] next_addr;
      logic [LINK_W-1:0] next_data;
      logic              prev_we;
      logic [LINK_W-1:0] prev_addr;
      logic [LINK_W-1:0] prev_data;
   } pool_wr_type;

   // Registered read data of one node
   typedef struct packed {
      logic [BYTE_W-1:0] node_byte;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } pool_rd_type;

endpackage

FILE: sv/dll_node_ram.sv
// ============================================================================
// dll_node_ram: node pool storage
// Byte, forward link and back link arrays with one registered read port
// shared by all three and a separate write port per array. Forward links
// carry a valid bit per entry; an entry not written since reset or clear
// reads as its free chain value (index plus one).
// ============================================================================
module dll_node_ram #(
   parameter  int POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF,
   localparam int IDX_W      = $clog2(POOL_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_links,
   input  logic [IDX_W-1:0]     rd_addr,
   input  dll_pkg::pool_wr_type wr,
   output dll_pkg::pool_rd_type rd
);

   localparam int LINK_W = dll_pkg::LINK_W;

   logic [dll_pkg::BYTE_W-1:0] byte_mem [POOL_DEPTH];
   logic [LINK_W-1:0]          next_mem [POOL_DEPTH];
   logic [LINK_W-1:0]          prev_mem [POOL_DEPTH];

   logic [POOL_DEPTH-1:0]      next_vld_ff, next_vld_in;
   logic                       rd_vld_ff;
   logic [IDX_W-1:0]           rd_addr_ff;
   logic [dll_pkg::BYTE_W-1:0] rd_byte_ff;
   logic [LINK_W-1:0]          rd_next_ff;
   logic [LINK_W-1:0]          rd_prev_ff;

   // Memory arrays: writes and registered reads
   always_ff @(posedge clock) begin
      if (wr.byte_we) begin
         byte_mem[wr.byte_addr[IDX_W-1:0]] <= wr.byte_data;
      end
      if (wr.next_we) begin
         next_mem[wr.next_addr[IDX_W-1:0]] <= wr.next_data;
      end
      if (wr.prev_we) begin
         prev_mem[wr.prev_addr[IDX_W-1:0]] <= wr.prev_data;
      end
      rd_byte_ff <= byte_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // Forward link valid bits: clear drops all, a write marks one
   always_comb begin
      next_vld_in = next_vld_ff;
      if (clear_links) begin
         next_vld_in = '0;
      end else if (wr.next_we) begin
         next_vld_in[wr.next_addr[IDX_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         next_vld_ff <= next_vld_in;
         rd_vld_ff   <= next_vld_ff[rd_addr];
      end
   end

   // Read data with free chain overlay on unwritten forward links
   always_comb begin
      rd.node_byte = rd_byte_ff;
      rd.prev      = rd_prev_ff;
      rd.next      = rd_vld_ff ? rd_next_ff : (LINK_W'(rd_addr_ff) + LINK_W'(1));
   end

endmodule

FILE: sv/dll_ctrl.sv
// ============================================================================
// dll_ctrl: list sequencer
// Holds head, tail, free chain head and node count, walks the node memory one node
// per cycle for searches and read-outs (read-outs only while the output is free),
// and sequences the link updates of each operation through the memory write ports.
// ============================================================================
module dll_ctrl #(
   parameter  int POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF,
   localparam int IDX_W      = $clog2(POOL_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dll_pkg::req_type     req_payload,
   input  logic                 out_free,
   output logic                 emit_valid,
   output dll_pkg::rsp_type     emit_item,
   output logic [IDX_W-1:0]     rd_addr,
   input  dll_pkg::pool_rd_type rd,
   output dll_pkg::pool_wr_type wr,
   output logic                 clear_links
);

   localparam int LINK_W = dll_pkg::LINK_W;
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

   // Map a stored link to a pool index; out-of-range links fall to slot zero
   function automatic logic [IDX_W-1:0] slot(input logic [LINK_W-1:0] x);
      slot = (int'(x) < POOL_DEPTH) ? x[IDX_W-1:0] : '0;
   endfunction

   dll_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [IDX_W-1:0]           tail_ff, tail_in;
   logic [IDX_W-1:0]           free_ff, free_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   logic [dll_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [dll_pkg::BYTE_W-1:0] value_ff, value_in;
   logic [dll_pkg::BYTE_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]           cur_ff, cur_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic [IDX_W-1:0]           p_ff, p_in;
   logic [IDX_W-1:0]           n_ff, n_in;
   logic [LINK_W-1:0]          p_next_ff, p_next_in;
   logic [LINK_W-1:0]          p_prev_ff, p_prev_in;
   dll_pkg::status_type        status_ff, status_in;

   logic                       full;
   logic                       walk_last;
   logic                       is_fwd;
   logic [dll_pkg::BYTE_W-1:0] target;
   logic [IDX_W-1:0]           walk_next;

   assign full      = (count_ff == CNT_W'(POOL_DEPTH));
   assign walk_last = ((k_ff + CNT_W'(1)) == count_ff);
   assign is_fwd    = (func_ff == dll_pkg::FN_READ_FWD);
   assign target    = (func_ff == dll_pkg::FN_INSERT) ? key_ff : value_ff;
   assign walk_next = is_fwd ? slot(rd.next) : slot(rd.prev);
   assign req_stall = (state_ff != dll_pkg::ST_IDLE);

   // Next state, list bookkeeping and memory accesses
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      func_in     = func_ff;
      value_in    = value_ff;
      key_in      = key_ff;
      cur_in      = cur_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      n_in        = n_ff;
      p_next_in   = p_next_ff;
      p_prev_in   = p_prev_ff;
      status_in   = status_ff;
      rd_addr     = cur_ff;
      wr          = '0;
      clear_links = 1'b0;
      emit_valid  = 1'b0;
      emit_item   = '0;

      case (state_ff)
         dll_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_payload.func;
               value_in = req_payload.value;
               key_in   = req_payload.key;
               state_in = dll_pkg::ST_DISPATCH;
            end
         end

         // Check the early-out cases and start the needed memory read
         dll_pkg::ST_DISPATCH: begin
            state_in  = dll_pkg::ST_RESP;
            status_in = dll_pkg::STAT_OK;
            case (func_ff)
               dll_pkg::FN_PUSH_TAIL, dll_pkg::FN_PUSH_HEAD: begin
                  if (full) begin
                     status_in = dll_pkg::STAT_FULL;
                  end else begin
                     rd_addr  = free_ff;
                     state_in = dll_pkg::ST_PUSH_WR;
                  end
               end
               dll_pkg::FN_INSERT: begin
                  if (count_ff == '0) begin
                     status_in = dll_pkg::STAT_EMPTY;
                  end else if (full) begin
                     status_in = dll_pkg::STAT_FULL;
                  end else begin
                     rd_addr  = head_ff;
                     cur_in   = head_ff;
                     k_in     = '0;
                     state_in = dll_pkg::ST_FIND;
                  end
               end
               dll_pkg::FN_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = dll_pkg::STAT_EMPTY;
                  end else begin
                     rd_addr  = head_ff;
                     cur_in   = head_ff;
                     k_in     = '0;
                     state_in = dll_pkg::ST_FIND;
                  end
               end
               dll_pkg::FN_READ_FWD, dll_pkg::FN_READ_BWD: begin
                  if (count_ff == '0) begin
                     status_in = dll_pkg::STAT_EMPTY;
                  end else begin
                     rd_addr  = is_fwd ? head_ff : tail_ff;
                     cur_in   = is_fwd ? head_ff : tail_ff;
                     k_in     = '0;
                     state_in = dll_pkg::ST_WALK;
                  end
               end
               dll_pkg::FN_CLEAR: begin
                  clear_links = 1'b1;
                  head_in     = '0;
                  tail_in     = '0;
                  free_in     = '0;
                  count_in    = '0;
               end
               default: begin
               end
            endcase
         end

         // Take the free head node and link it at one end
         dll_pkg::ST_PUSH_WR: begin
            free_in      = slot(rd.next);
            count_in     = count_ff + CNT_W'(1);
            wr.byte_we   = 1'b1;
            wr.byte_addr = LINK_W'(free_ff);
            wr.byte_data = value_ff;
            if (count_ff == '0) begin
               head_in = free_ff;
               tail_in = free_ff;
            end else if (func_ff == dll_pkg::FN_PUSH_TAIL) begin
               wr.prev_we   = 1'b1;
               wr.prev_addr = LINK_W'(free_ff);
               wr.prev_data = LINK_W'(tail_ff);
               wr.next_we   = 1'b1;
               wr.next_addr = LINK_W'(tail_ff);
               wr.next_data = LINK_W'(free_ff);
               tail_in      = free_ff;
            end else begin
               wr.next_we   = 1'b1;
               wr.next_addr = LINK_W'(free_ff);
               wr.next_data = LINK_W'(head_ff);
               wr.prev_we   = 1'b1;
               wr.prev_addr = LINK_W'(head_ff);
               wr.prev_data = LINK_W'(free_ff);
               head_in      = free_ff;
            end
            state_in = dll_pkg::ST_RESP;
         end

         // Search from the head, one node per cycle
         dll_pkg::ST_FIND: begin
            if (rd.node_byte == target) begin
               p_in      = cur_ff;
               p_next_in = rd.next;
               p_prev_in = rd.prev;
               if (func_ff == dll_pkg::FN_INSERT) begin
                  rd_addr  = free_ff;
                  state_in = dll_pkg::ST_INS_WR;
               end else begin
                  state_in = dll_pkg::ST_DEL_WR;
               end
            end else if (walk_last) begin
               status_in = dll_pkg::STAT_NOT_FOUND;
               state_in  = dll_pkg::ST_RESP;
            end else begin
               rd_addr = slot(rd.next);
               cur_in  = slot(rd.next);
               k_in    = k_ff + CNT_W'(1);
            end
         end

         // New node after the found one: its own fields first
         dll_pkg::ST_INS_WR: begin
            n_in         = free_ff;
            free_in      = slot(rd.next);
            count_in     = count_ff + CNT_W'(1);
            wr.byte_we   = 1'b1;
            wr.byte_addr = LINK_W'(free_ff);
            wr.byte_data = value_ff;
            wr.prev_we   = 1'b1;
            wr.prev_addr = LINK_W'(free_ff);
            wr.prev_data = LINK_W'(p_ff);
            if (p_ff == tail_ff) begin
               tail_in = free_ff;
            end else begin
               wr.next_we   = 1'b1;
               wr.next_addr = LINK_W'(free_ff);
               wr.next_data = p_next_ff;
            end
            state_in = dll_pkg::ST_INS_LINK;
         end

         // Then the neighbors' links; tail equal to the new node means it was appended
         dll_pkg::ST_INS_LINK: begin
            wr.next_we   = 1'b1;
            wr.next_addr = LINK_W'(p_ff);
            wr.next_data = LINK_W'(n_ff);
            if (tail_ff != n_ff) begin
               wr.prev_we   = 1'b1;
               wr.prev_addr = LINK_W'(slot(p_next_ff));
               wr.prev_data = LINK_W'(n_ff);
            end
            state_in = dll_pkg::ST_RESP;
         end

         // Unlink the found node
         dll_pkg::ST_DEL_WR: begin
            if (count_ff == CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (p_ff == head_ff) begin
               head_in = slot(p_next_ff);
            end else if (p_ff == tail_ff) begin
               tail_in = slot(p_prev_ff);
            end else begin
               wr.next_we   = 1'b1;
               wr.next_addr = LINK_W'(slot(p_prev_ff));
               wr.next_data = p_next_ff;
               wr.prev_we   = 1'b1;
               wr.prev_addr = LINK_W'(slot(p_next_ff));
               wr.prev_data = p_prev_ff;
            end
            state_in = dll_pkg::ST_DEL_GIVE;
         end

         // Return it to the front of the free chain
         dll_pkg::ST_DEL_GIVE: begin
            wr.next_we   = 1'b1;
            wr.next_addr = LINK_W'(p_ff);
            wr.next_data = LINK_W'(free_ff);
            free_in      = p_ff;
            count_in     = count_ff - CNT_W'(1);
            state_in     = dll_pkg::ST_RESP;
         end

         // Read-out: one byte per transfer; read address holds while stalled
         dll_pkg::ST_WALK: begin
            if (out_free) begin
               emit_valid       = 1'b1;
               emit_item.status = dll_pkg::STAT_OK;
               emit_item.data   = rd.node_byte;
               emit_item.last   = walk_last;
               emit_item.count  = dll_pkg::COUNT_W'(count_ff);
               if (walk_last) begin
                  state_in = dll_pkg::ST_IDLE;
               end else begin
                  rd_addr = walk_next;
                  cur_in  = walk_next;
                  k_in    = k_ff + CNT_W'(1);
               end
            end
         end

         // Single result
         dll_pkg::ST_RESP: begin
            if (out_free) begin
               emit_valid       = 1'b1;
               emit_item.status = status_ff;
               emit_item.data   = '0;
               emit_item.last   = 1'b1;
               emit_item.count  = dll_pkg::COUNT_W'(count_ff);
               state_in         = dll_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dll_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dll_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   // Operation and walk registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      value_ff  <= value_in;
      key_ff    <= key_in;
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      p_ff      <= p_in;
      n_ff      <= n_in;
      p_next_ff <= p_next_in;
      p_prev_ff <= p_prev_in;
      status_ff <= status_in;
   end

endmodule

FILE: sv/doubly_linked_char_list_unit.sv
// ============================================================================
// doubly_linked_char_list_unit: doubly linked byte list in a node pool
// Push at either end, insert after a key, delete by value, read out in
// either direction, and clear, over a pool of POOL_DEPTH nodes.
// ============================================================================
// One operation is in flight at a time; req_stall is high from the transfer
// until the last result has entered the output register. The node memory has
// one registered read port, and searches and read-outs follow one link per
// cycle through it, read-outs only while the output register is free. A
// read-out returns count results, one per cycle without output stalls. The
// output register lets a result wait while the next request is taken. No
// clearing pass is needed after reset or clear: the forward links carry
// per-entry valid bits.
// ============================================================================
module doubly_linked_char_list_unit #(
   parameter int POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dll_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dll_pkg::rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(POOL_DEPTH);

   logic                 out_free;
   logic                 emit_valid;
   dll_pkg::rsp_type     emit_item;
   logic [IDX_W-1:0]     rd_addr;
   dll_pkg::pool_rd_type rd;
   dll_pkg::pool_wr_type wr;
   logic                 clear_links;

   logic                 rsp_valid_ff;
   dll_pkg::rsp_type     rsp_payload_ff;

   dll_ctrl #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_free    (out_free),
      .emit_valid  (emit_valid),
      .emit_item   (emit_item),
      .rd_addr     (rd_addr),
      .rd          (rd),
      .wr          (wr),
      .clear_links (clear_links)
   );

   dll_node_ram #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_ram (
      .clock       (clock),
      .reset       (reset),
      .clear_links (clear_links),
      .rd_addr     (rd_addr),
      .wr          (wr),
      .rd          (rd)
   );

   // Output register: free when empty or when its result transfers now
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_payload_ff <= emit_item;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: tb/tb_doubly_linked_char_list_unit.sv
// ============================================================================
// tb_doubly_linked_char_list_unit: self-checking bench for the linked byte list
// Drives push, insert, delete, read-out, clear and unused operations through
// the request channel and scores every response against an in-bench model of
// the node pool, or the row for typed rows. A short directed table covers the
// empty and sole-node cases and each link-fixing path. Random traffic follows,
// with a pool overflow, random stalls on both channels and a long response hold.
// ============================================================================
module tb_doubly_linked_char_list_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF;
   localparam logic [dll_pkg::FUNC_W-1:0] FN_UNUSED = 3'd7;
   localparam int LONG_HOLD = 300;
   localparam int END_DRAIN = 40;
   localparam int CYCLE_LIMIT = 1000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dll_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dll_pkg::rsp_type rsp_payload;

   // In-bench copy of the node pool
   logic [dll_pkg::BYTE_W-1:0] m_byte [POOL_DEPTH];
   logic [dll_pkg::LINK_W-1:0] m_next [POOL_DEPTH];
   logic [dll_pkg::LINK_W-1:0] m_prev [POOL_DEPTH];
   int unsigned                m_head, m_tail, m_free, m_count;

   dll_pkg::rsp_type op_results_q[$];
   dll_pkg::rsp_type pending_rsp_q[$];
   int               fail_count = 0;
   // number of long holds asked for; the stall generator keeps its own tally
   int               hold_rsp_req = 0;

   typedef struct {
      logic [dll_pkg::FUNC_W-1:0]  func;
      logic [dll_pkg::BYTE_W-1:0]  value;
      logic [dll_pkg::BYTE_W-1:0]  key;
      bit                          typed;
      dll_pkg::status_type         status;
      logic [dll_pkg::COUNT_W-1:0] count;
   } dir_row_type;

   dir_row_type dir_rows[$];

   doubly_linked_char_list_unit #(
      .POOL_DEPTH(POOL_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // List model
   // ---------------------------------------------------------------------
   function automatic int unsigned slot_of(input int unsigned x);
      return (x < POOL_DEPTH) ? x : 0;
   endfunction

   function automatic void rebuild_free_chain();
      int i;
      for (i = 0; i < POOL_DEPTH; i++) m_next[i] = dll_pkg::LINK_W'(i + 1);
      m_free  = 0;
      m_head  = 0;
      m_tail  = 0;
      m_count = 0;
   endfunction

   function automatic int unsigned take_node(input logic [dll_pkg::BYTE_W-1:0] b);
      int unsigned n;
      n         = slot_of(m_free);
      m_free    = slot_of(32'(m_next[n]));
      m_byte[n] = b;
      m_count++;
      return n;
   endfunction

   function automatic void give_node(input int unsigned n);
      int unsigned s;
      s         = slot_of(n);
      m_next[s] = dll_pkg::LINK_W'(m_free);
      m_free    = s;
      m_count--;
   endfunction

   // first node holding b, walking from the head; -1 on a miss
   function automatic int find_node(input logic [dll_pkg::BYTE_W-1:0] b);
      int unsigned p, k;
      p = slot_of(m_head);
      for (k = 0; k < m_count; k++) begin
         if (m_byte[p] == b) return int'(p);
         p = slot_of(32'(m_next[p]));
      end
      return -1;
   endfunction

   function automatic void emit_result(input dll_pkg::status_type st,
                                       input logic [dll_pkg::BYTE_W-1:0] d,
                                       input logic l);
      dll_pkg::rsp_type x;
      x.status = st;
      x.data   = d;
      x.last   = l;
      x.count  = dll_pkg::COUNT_W'(m_count);
      op_results_q.push_back(x);
   endfunction

   function automatic void predict_list_op(input dll_pkg::req_type r);
      int unsigned         n, p, k;
      int                  hit;
      bit                  full;
      dll_pkg::status_type st;
      st   = dll_pkg::STAT_OK;
      full = (m_count >= POOL_DEPTH);
      case (r.func)
         dll_pkg::FN_PUSH_TAIL, dll_pkg::FN_PUSH_HEAD: begin
            if (full) begin
               st = dll_pkg::STAT_FULL;
            end else begin
               n = take_node(r.value);
               if (m_count == 1) begin
                  m_head = n;
                  m_tail = n;
               end else if (r.func == dll_pkg::FN_PUSH_TAIL) begin
                  m_prev[n]               = dll_pkg::LINK_W'(m_tail);
                  m_next[slot_of(m_tail)] = dll_pkg::LINK_W'(n);
                  m_tail                  = n;
               end else begin
                  m_next[n]               = dll_pkg::LINK_W'(m_head);
                  m_prev[slot_of(m_head)] = dll_pkg::LINK_W'(n);
                  m_head                  = n;
               end
            end
         end
         dll_pkg::FN_INSERT: begin
            hit = find_node(r.key);
            if (m_count == 0) st = dll_pkg::STAT_EMPTY;
            else if (full) st = dll_pkg::STAT_FULL;
            else if (hit < 0) st = dll_pkg::STAT_NOT_FOUND;
            else begin
               p         = unsigned'(hit);
               n         = take_node(r.value);
               m_prev[n] = dll_pkg::LINK_W'(p);
               if (p == m_tail) begin
                  m_tail = n;
               end else begin
                  m_next[n]                       = m_next[p];
                  m_prev[slot_of(32'(m_next[p]))] = dll_pkg::LINK_W'(n);
               end
               m_next[p] = dll_pkg::LINK_W'(n);
            end
         end
         dll_pkg::FN_DELETE: begin
            hit = find_node(r.value);
            if (m_count == 0) st = dll_pkg::STAT_EMPTY;
            else if (hit < 0) st = dll_pkg::STAT_NOT_FOUND;
            else begin
               p = unsigned'(hit);
               if (m_count == 1) begin
                  m_head = 0;
                  m_tail = 0;
               end else if (p == m_head) begin
                  m_head = slot_of(32'(m_next[p]));
               end else if (p == m_tail) begin
                  m_tail = slot_of(32'(m_prev[p]));
               end else begin
                  m_next[slot_of(32'(m_prev[p]))] = m_next[p];
                  m_prev[slot_of(32'(m_next[p]))] = m_prev[p];
               end
               give_node(p);
            end
         end
         dll_pkg::FN_READ_FWD, dll_pkg::FN_READ_BWD: begin
            if (m_count == 0) begin
               st = dll_pkg::STAT_EMPTY;
            end else begin
               p = (r.func == dll_pkg::FN_READ_FWD) ? slot_of(m_head) : slot_of(m_tail);
               for (k = 0; k < m_count; k++) begin
                  emit_result(dll_pkg::STAT_OK, m_byte[p], (k + 1 == m_count));
                  p = (r.func == dll_pkg::FN_READ_FWD) ? slot_of(32'(m_next[p]))
                                                       : slot_of(32'(m_prev[p]));
               end
               return;
            end
         end
         dll_pkg::FN_CLEAR: rebuild_free_chain();
         default: ;
      endcase
      emit_result(st, '0, 1'b1);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // mostly zero, often short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [dll_pkg::BYTE_W-1:0] rand_byte();
      return dll_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic dll_pkg::req_type make_req(input logic [dll_pkg::FUNC_W-1:0] f,
                                                 input logic [dll_pkg::BYTE_W-1:0] v,
                                                 input logic [dll_pkg::BYTE_W-1:0] k);
      dll_pkg::req_type r;
      r.func  = f;
      r.value = v;
      r.key   = k;
      return r;
   endfunction

   // byte from the current list half the time, so finds mostly hit
   function automatic logic [dll_pkg::BYTE_W-1:0] pick_byte();
      int unsigned p, k;
      int          r;
      r = $urandom_range(0, 9);
      if (r < 5 && m_count > 0) begin
         p = slot_of(m_head);
         for (k = $urandom_range(0, m_count - 1); k > 0; k--) p = slot_of(32'(m_next[p]));
         return m_byte[p];
      end
      if (r < 7) return dll_pkg::BYTE_W'(8'h30 + $urandom_range(0, 3));
      return rand_byte();
   endfunction

   function automatic void add_row(input logic [dll_pkg::FUNC_W-1:0] f,
                                   input logic [dll_pkg::BYTE_W-1:0] v,
                                   input logic [dll_pkg::BYTE_W-1:0] k, input bit typed,
                                   input dll_pkg::status_type st, input int cnt);
      dir_row_type row;
      row.func   = f;
      row.value  = v;
      row.key    = k;
      row.typed  = typed;
      row.status = st;
      row.count  = dll_pkg::COUNT_W'(cnt);
      dir_rows.push_back(row);
   endfunction

   // Offer one request, hold it until transfer, then queue its responses.
   // A typed row replaces the model's answer with the one given.
   task automatic send_req(input dll_pkg::req_type r, input bit typed,
                           input dll_pkg::rsp_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_list_op(r);
      if (typed) begin
         op_results_q.delete();
         pending_rsp_q.push_back(want);
      end else begin
         while (op_results_q.size() > 0) pending_rsp_q.push_back(op_results_q.pop_front());
      end
   endtask

   task automatic send_random(input int n_items);
      int                         i, r;
      logic [dll_pkg::FUNC_W-1:0] f;
      for (i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 22) f = dll_pkg::FN_PUSH_TAIL;
         else if (r < 40) f = dll_pkg::FN_PUSH_HEAD;
         else if (r < 58) f = dll_pkg::FN_INSERT;
         else if (r < 76) f = dll_pkg::FN_DELETE;
         else if (r < 85) f = dll_pkg::FN_READ_FWD;
         else if (r < 93) f = dll_pkg::FN_READ_BWD;
         else if (r < 97) f = dll_pkg::FN_CLEAR;
         else f = FN_UNUSED;
         send_req(make_req(f, pick_byte(), pick_byte()), 1'b0, '0);
      end
   endtask

   // fill the pool, hit it while full, read it both ways, trim it, then insert and read back
   task automatic fill_pool();
      int i;
      while (m_count < POOL_DEPTH)
         send_req(make_req($urandom_range(0, 1) ? dll_pkg::FN_PUSH_HEAD
                                                : dll_pkg::FN_PUSH_TAIL,
                           pick_byte(), rand_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_PUSH_TAIL, pick_byte(), pick_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_PUSH_HEAD, pick_byte(), pick_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_INSERT, pick_byte(), pick_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_INSERT, rand_byte(), 8'hEE), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_READ_FWD, rand_byte(), rand_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_READ_BWD, rand_byte(), rand_byte()), 1'b0, '0);
      for (i = 0; i < 6; i++)
         send_req(make_req(dll_pkg::FN_DELETE, pick_byte(), pick_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_INSERT, pick_byte(), pick_byte()), 1'b0, '0);
      send_req(make_req(dll_pkg::FN_READ_BWD, 8'h00, 8'h00), 1'b0, '0);
   endtask

   // stop offering and wait until every expected response has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stim
      dll_pkg::rsp_type want;
      dir_row_type      row;
      int               i;

      rebuild_free_chain();

      // empty list corners
      add_row(dll_pkg::FN_READ_FWD,  8'h00, 8'h00, 1'b1, dll_pkg::STAT_EMPTY,     0);
      add_row(dll_pkg::FN_READ_BWD,  8'hFF, 8'hFF, 1'b1, dll_pkg::STAT_EMPTY,     0);
      add_row(dll_pkg::FN_DELETE,    8'h00, 8'hFF, 1'b1, dll_pkg::STAT_EMPTY,     0);
      add_row(dll_pkg::FN_INSERT,    8'hFF, 8'h00, 1'b1, dll_pkg::STAT_EMPTY,     0);
      add_row(FN_UNUSED,             8'hFF, 8'hFF, 1'b1, dll_pkg::STAT_OK,        0);
      // sole node in and out
      add_row(dll_pkg::FN_PUSH_TAIL, 8'h00, 8'hFF, 1'b1, dll_pkg::STAT_OK,        1);
      add_row(dll_pkg::FN_DELETE,    8'h00, 8'h00, 1'b1, dll_pkg::STAT_OK,        0);
      // build 00 11 FF 55 AA
      add_row(dll_pkg::FN_PUSH_TAIL, 8'hFF, 8'h00, 1'b1, dll_pkg::STAT_OK,        1);
      add_row(dll_pkg::FN_PUSH_HEAD, 8'h00, 8'h00, 1'b1, dll_pkg::STAT_OK,        2);
      add_row(dll_pkg::FN_PUSH_TAIL, 8'h55, 8'h00, 1'b1, dll_pkg::STAT_OK,        3);
      add_row(dll_pkg::FN_INSERT,    8'hAA, 8'h55, 1'b1, dll_pkg::STAT_OK,        4);
      add_row(dll_pkg::FN_INSERT,    8'h11, 8'h00, 1'b1, dll_pkg::STAT_OK,        5);
      add_row(dll_pkg::FN_INSERT,    8'h22, 8'h77, 1'b1, dll_pkg::STAT_NOT_FOUND, 5);
      add_row(dll_pkg::FN_READ_FWD,  8'h00, 8'h00, 1'b0, dll_pkg::STAT_OK,        0);
      add_row(dll_pkg::FN_READ_BWD,  8'h00, 8'h00, 1'b0, dll_pkg::STAT_OK,        0);
      // delete head, tail, middle, then a miss
      add_row(dll_pkg::FN_DELETE,    8'h00, 8'h00, 1'b1, dll_pkg::STAT_OK,        4);
      add_row(dll_pkg::FN_DELETE,    8'hAA, 8'h00, 1'b1, dll_pkg::STAT_OK,        3);
      add_row(dll_pkg::FN_DELETE,    8'hFF, 8'h00, 1'b1, dll_pkg::STAT_OK,        2);
      add_row(dll_pkg::FN_DELETE,    8'h99, 8'h00, 1'b1, dll_pkg::STAT_NOT_FOUND, 2);
      // mid-list insert must fix the back link of the next node
      add_row(dll_pkg::FN_INSERT,    8'h33, 8'h11, 1'b0, dll_pkg::STAT_OK,        0);
      add_row(dll_pkg::FN_READ_BWD,  8'h00, 8'h00, 1'b0, dll_pkg::STAT_OK,        0);
      add_row(dll_pkg::FN_CLEAR,     8'hFF, 8'hFF, 1'b1, dll_pkg::STAT_OK,        0);
      add_row(dll_pkg::FN_READ_FWD,  8'h00, 8'h00, 1'b1, dll_pkg::STAT_EMPTY,     0);
      add_row(dll_pkg::FN_PUSH_HEAD, 8'h5A, 8'hA5, 1'b1, dll_pkg::STAT_OK,        1);
      add_row(dll_pkg::FN_READ_BWD,  8'hA5, 8'h5A, 1'b0, dll_pkg::STAT_OK,        0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < dir_rows.size(); i++) begin
         row         = dir_rows[i];
         want.status = row.status;
         want.data   = '0;
         want.last   = 1'b1;
         want.count  = row.count;
         send_req(make_req(row.func, row.value, row.key), row.typed, want);
      end

      // let everything come back before the random phase
      wait_drained();

      // random mix under one long response hold
      hold_rsp_req++;
      send_random(30);
      send_req(make_req(dll_pkg::FN_CLEAR, 8'h00, 8'h00), 1'b0, '0);
      fill_pool();
      wait_drained();
      send_random(30);

      wait_drained();
      repeat (END_DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response-side stall generator
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int len;
      int hold_seen;
      hold_seen = 0;
      forever begin
         if (hold_rsp_req != hold_seen) begin
            hold_seen = hold_rsp_req;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            len = pick_gap();
            if (len > 0) begin
               rsp_stall <= 1'b1;
               repeat (len) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         // occasional long stretch with no stalls
         len = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
         repeat (len) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Response scoreboard: each transfer against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dll_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected response: status %0d data %0h last %0d count %0d",
                   rsp_payload.status, rsp_payload.data, rsp_payload.last,
                   rsp_payload.count);
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.data !== want.data) begin
               $error("data mismatch: expected %0h, actual %0h", want.data, rsp_payload.data);
               fail_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_payload.last);
               fail_count++;
            end
            if (rsp_payload.count !== want.count) begin
               $error("count mismatch: expected %0d, actual %0d",
                      want.count, rsp_payload.count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

endmodule
